// ----- sv/ljpf_pkg.sv -----
// ljpf_pkg: shared types, constants and register codes of the pair force block
// depends on nothing; imported by every ljpf module and by the top level
`default_nettype none

package ljpf_pkg;

  // pipeline depth per unit
  localparam int unsigned GeomStages = 5;
  localparam int unsigned QSteps     = 32;
  localparam int unsigned PolyStages = 11;
  localparam int unsigned FSteps     = 47;
  localparam int unsigned Latency    = GeomStages + QSteps + 1 + PolyStages + FSteps + 1 + 1;

  // fixed point limits
  localparam logic [62:0] WCap   = 63'h4000000000000000;
  localparam logic [47:0] PosMax = 48'h7FFFFFFFFFFF;
  localparam logic [47:0] NegMax = 48'h800000000000;
  localparam logic [31:0] BoxReset = 32'd655360;
  localparam logic [1:0]  SpecOne  = 2'd1;
  localparam logic [1:0]  SpecNone = 2'd0;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BOX_X, REG_BOX_Y, REG_BOX_Z, REG_FILT_FIRST, REG_FILT_SECOND,
    REG_PAR_ONE, REG_PAR_TWO, REG_PAR_MIX
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][31:0] box;
    logic [1:0]       filt_first;
    logic [1:0]       filt_second;
    logic [63:0]      par_one;
    logic [63:0]      par_two;
    logic [63:0]      par_mix;
  } cfg_t;

  // selected pair parameters and filter result
  typedef struct packed {
    logic [19:0] eps;
    logic [23:0] s2;
    logic [19:0] ecut;
    logic        on;
  } par_t;

  // per request data carried alongside the reciprocal and polynomial stages
  typedef struct packed {
    logic [19:0]      eps;
    logic [19:0]      ecut;
    logic             on;
    logic             zero;
    logic [2:0]       dneg;
    logic [2:0][31:0] dmag;
  } side_t;

  // per request data carried alongside the force dividers
  typedef struct packed {
    logic        on;
    logic        zero;
    logic        gneg;
    logic [2:0]  dneg;
    logic [47:0] energy;
  } fside_t;

endpackage

`default_nettype wire

// ----- sv/ljpf_geom.sv -----
// ljpf_geom: parameter select, minimum image deltas and squared distance
// depends on ljpf_pkg
`default_nettype none

module ljpf_geom (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ljpf_pkg::cfg_t          cfg_i,
  input  logic                    in_valid_i,
  input  logic [2:0][31:0]        first_pos_i,
  input  logic [2:0][31:0]        second_pos_i,
  input  logic [1:0]              first_spec_i,
  input  logic [1:0]              second_spec_i,
  output logic                    valid_o,
  output logic [63:0]             r2_o,
  output logic [23:0]             s2_o,
  output ljpf_pkg::side_t         side_o
);
  import ljpf_pkg::*;

  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  par_t               par_d, par1_q, par2_q, par3_q, par4_q, par5_q;
  logic signed [32:0] d1_d [3];
  logic signed [32:0] d1_q [3];
  logic signed [32:0] d2_d [3];
  logic signed [32:0] d2_q [3];
  logic [2:0]         dneg3_d, dneg3_q, dneg4_q, dneg5_q;
  logic [2:0][31:0]   mag3_d, mag3_q, mag4_q, mag5_q;
  logic               zero3_d, zero3_q, zero4_q, zero5_q;
  logic [2:0][63:0]   sq4_d, sq4_q;
  logic [65:0]        sum5;
  logic [63:0]        r2_5_d, r2_5_q;

  // parameter select and species filter
  always_comb begin
    logic [63:0] p;
    if (first_spec_i == second_spec_i) begin
      p = (first_spec_i == SpecOne) ? cfg_i.par_one : cfg_i.par_two;
    end else begin
      p = cfg_i.par_mix;
    end
    par_d.eps  = p[63:44];
    par_d.s2   = p[43:20];
    par_d.ecut = p[19:0];
    par_d.on   = (cfg_i.filt_first == SpecNone && cfg_i.filt_second == SpecNone) ||
                 (first_spec_i == cfg_i.filt_first && second_spec_i == cfg_i.filt_second);
  end

  // raw deltas
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1_d[k] = $signed({1'b0, first_pos_i[k]}) - $signed({1'b0, second_pos_i[k]});
    end
  end

  // one minimum image step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [33:0] twod;
      logic signed [33:0] lx;
      twod = $signed({d1_q[k], 1'b0});
      lx   = $signed({2'b00, cfg_i.box[k]});
      if (twod >= lx) begin
        d2_d[k] = d1_q[k] - $signed({1'b0, cfg_i.box[k]});
      end else if (twod <= -lx) begin
        d2_d[k] = d1_q[k] + $signed({1'b0, cfg_i.box[k]});
      end else begin
        d2_d[k] = d1_q[k];
      end
    end
  end

  // magnitude and sign
  always_comb begin
    zero3_d = 1'b1;
    for (int k = 0; k < 3; k++) begin
      logic signed [32:0] neg;
      neg        = -d2_q[k];
      dneg3_d[k] = d2_q[k][32];
      mag3_d[k]  = d2_q[k][32] ? neg[31:0] : d2_q[k][31:0];
      if (d2_q[k] != '0) begin
        zero3_d = 1'b0;
      end
    end
  end

  // squares
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq4_d[k] = 64'(mag3_q[k]) * 64'(mag3_q[k]);
    end
  end

  // saturating sum of squares
  always_comb begin
    sum5   = 66'(sq4_q[0]) + 66'(sq4_q[1]) + 66'(sq4_q[2]);
    r2_5_d = (sum5[65:64] != 2'b00) ? '1 : sum5[63:0];
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    par1_q  <= par_d;
    par2_q  <= par1_q;
    par3_q  <= par2_q;
    par4_q  <= par3_q;
    par5_q  <= par4_q;
    d1_q    <= d1_d;
    d2_q    <= d2_d;
    dneg3_q <= dneg3_d;
    mag3_q  <= mag3_d;
    zero3_q <= zero3_d;
    dneg4_q <= dneg3_q;
    mag4_q  <= mag3_q;
    zero4_q <= zero3_q;
    sq4_q   <= sq4_d;
    dneg5_q <= dneg4_q;
    mag5_q  <= mag4_q;
    zero5_q <= zero4_q;
    r2_5_q  <= r2_5_d;
  end

  assign valid_o     = v5_q;
  assign r2_o        = r2_5_q;
  assign s2_o        = par5_q.s2;
  assign side_o.eps  = par5_q.eps;
  assign side_o.ecut = par5_q.ecut;
  assign side_o.on   = par5_q.on;
  assign side_o.zero = zero5_q;
  assign side_o.dneg = dneg5_q;
  assign side_o.dmag = mag5_q;

endmodule

`default_nettype wire

// ----- sv/ljpf_recip.sv -----
// ljpf_recip: pipelined restoring divider forming s2/r2 in Q8.24, one bit a stage
// depends on ljpf_pkg
`default_nettype none

module ljpf_recip (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [63:0]     r2_i,
  input  logic [23:0]     s2_i,
  input  ljpf_pkg::side_t side_i,
  output logic            valid_o,
  output logic [31:0]     q_o,
  output logic [63:0]     r2_o,
  output ljpf_pkg::side_t side_o
);
  import ljpf_pkg::*;

  logic        v_q    [0:QSteps];
  logic [63:0] rem_q  [0:QSteps];
  logic [63:0] rem_d  [1:QSteps];
  logic [31:0] quo_q  [0:QSteps];
  logic [31:0] quo_d  [1:QSteps];
  logic [63:0] den_q  [0:QSteps];
  logic        cap_q  [0:QSteps];
  side_t       side_q [0:QSteps];
  logic [63:0] num_hi;

  // quotient of 2^32 or more clamps
  assign num_hi = {32'b0, s2_i, 8'b0};

  // one quotient bit per stage
  always_comb begin
    for (int k = 1; k <= QSteps; k++) begin
      logic [64:0] tmp;
      logic [64:0] dif;
      logic        ge;
      tmp      = {rem_q[k-1], 1'b0};
      dif      = tmp - {1'b0, den_q[k-1]};
      ge       = tmp >= {1'b0, den_q[k-1]};
      rem_d[k] = ge ? dif[63:0] : tmp[63:0];
      quo_d[k] = {quo_q[k-1][30:0], ge};
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QSteps; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= QSteps; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_hi;
    quo_q[0]  <= '0;
    den_q[0]  <= r2_i;
    cap_q[0]  <= r2_i <= num_hi;
    side_q[0] <= side_i;
    for (int k = 1; k <= QSteps; k++) begin
      rem_q[k]  <= rem_d[k];
      quo_q[k]  <= quo_d[k];
      den_q[k]  <= den_q[k-1];
      cap_q[k]  <= cap_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = v_q[QSteps];
  assign q_o     = cap_q[QSteps] ? '1 : quo_q[QSteps];
  assign r2_o    = den_q[QSteps];
  assign side_o  = side_q[QSteps];

endmodule

`default_nettype wire

// ----- sv/ljpf_poly.sv -----
// ljpf_poly: powers of s2/r2, shifted energy and force numerators
// depends on ljpf_pkg
`default_nettype none

module ljpf_poly (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [31:0]      q_i,
  input  logic [63:0]      r2_i,
  input  ljpf_pkg::side_t  side_i,
  output logic             valid_o,
  output logic [63:0]      r2_o,
  output logic [2:0][94:0] p_o,
  output ljpf_pkg::fside_t fside_o
);
  import ljpf_pkg::*;

  logic        v_q    [1:PolyStages];
  side_t       side_q [1:PolyStages];
  logic [63:0] r2_q   [1:PolyStages];

  logic [31:0] q1_q;
  logic [63:0] qq1_d, qq1_q;
  logic [47:0] ph2_d, ph2_q;
  logic [55:0] pl2_d, pl2_q;
  logic [71:0] r6sum;
  logic [47:0] r6_3_q, r6_4_q, r6_5_q;
  logic [47:0] hh4_d, hl4_d, ll4_d, hh4_q, hl4_q, ll4_q;
  logic [95:0] r12sum;
  logic [62:0] r12_5_d, r12_5_q;
  logic [63:0] t6_d, g6_d, t6_q, g6_q;
  logic [63:0] tneg_v, gneg_v;
  logic        tneg7_q, gneg7_q, tneg8_q, gneg8_q, tneg9_q, gneg9_q, gneg10_q, gneg11_q;
  logic [62:0] tmag7_q, gmag7_q;
  logic [21:0] eps4_7_q;
  logic [25:0] eps48_7_d, eps48_7_q;
  logic [53:0] tl8_d, tl8_q;
  logic [52:0] th8_d, th8_q;
  logic [57:0] gl8_d, gl8_q;
  logic [56:0] gh8_d, gh8_q;
  logic [85:0] eprod;
  logic [89:0] gprod;
  logic [62:0] emag9_d, hm9_d, emag9_q, hm9_q;
  logic [63:0] esg10_d, esg10_q;
  logic [2:0][63:0] fl10_d, fl10_q;
  logic [2:0][62:0] fh10_d, fh10_q;
  logic [63:0] ecut_x, e11;
  logic [47:0] energy11_d, energy11_q;
  logic [2:0][94:0] p11_d, p11_q;

  // q squared, then q^3 partial products
  assign qq1_d = 64'(q_i) * 64'(q_i);
  assign ph2_d = 48'(qq1_q[63:48]) * 48'(q1_q);
  assign pl2_d = 56'(qq1_q[47:24]) * 56'(q1_q);
  assign r6sum = {ph2_q, 24'b0} + {16'b0, pl2_q};

  // r6 squared in three partial products
  assign hh4_d = 48'(r6_3_q[47:24]) * 48'(r6_3_q[47:24]);
  assign hl4_d = 48'(r6_3_q[47:24]) * 48'(r6_3_q[23:0]);
  assign ll4_d = 48'(r6_3_q[23:0]) * 48'(r6_3_q[23:0]);
  always_comb begin
    logic [71:0] s;
    r12sum  = {hh4_q, 48'b0} + {23'b0, hl4_q, 25'b0} + {48'b0, ll4_q};
    s       = r12sum[95:24];
    r12_5_d = (s > 72'(WCap)) ? WCap : s[62:0];
  end

  // energy and force brackets
  assign t6_d   = {1'b0, r12_5_q} - {16'b0, r6_5_q};
  assign g6_d   = {1'b0, r12_5_q} - {17'b0, r6_5_q[47:1]};
  assign tneg_v = -t6_q;
  assign gneg_v = -g6_q;
  assign eps48_7_d = {1'b0, side_q[6].eps, 5'b0} + {2'b0, side_q[6].eps, 4'b0};

  // eps products in 32 bit halves
  assign tl8_d = 54'(tmag7_q[31:0]) * 54'(eps4_7_q);
  assign th8_d = 53'(tmag7_q[62:32]) * 53'(eps4_7_q);
  assign gl8_d = 58'(gmag7_q[31:0]) * 58'(eps48_7_q);
  assign gh8_d = 57'(gmag7_q[62:32]) * 57'(eps48_7_q);
  always_comb begin
    logic [69:0] es;
    logic [73:0] gs;
    eprod   = {th8_q, 32'b0} + {32'b0, tl8_q};
    gprod   = {1'b0, gh8_q, 32'b0} + {32'b0, gl8_q};
    es      = eprod[85:16];
    gs      = gprod[89:16];
    emag9_d = (es > 70'(WCap)) ? WCap : es[62:0];
    hm9_d   = (gs > 74'(WCap)) ? WCap : gs[62:0];
  end

  // signed energy and force numerator partial products
  assign esg10_d = tneg9_q ? (64'b0 - {1'b0, emag9_q}) : {1'b0, emag9_q};
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fl10_d[k] = 64'(hm9_q[31:0]) * 64'(side_q[9].dmag[k]);
      fh10_d[k] = 63'(hm9_q[62:32]) * 63'(side_q[9].dmag[k]);
      p11_d[k]  = {fh10_q[k], 32'b0} + {31'b0, fl10_q[k]};
    end
  end

  // energy shift and 48 bit saturation
  always_comb begin
    ecut_x = {{36{side_q[10].ecut[19]}}, side_q[10].ecut, 8'b0};
    e11    = esg10_q - ecut_x;
    if ($signed(e11) > $signed({16'b0, PosMax})) begin
      energy11_d = PosMax;
    end else if ($signed(e11) < $signed({16'hFFFF, NegMax})) begin
      energy11_d = NegMax;
    end else begin
      energy11_d = e11[47:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= PolyStages; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[1] <= valid_i;
      for (int k = 2; k <= PolyStages; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    side_q[1] <= side_i;
    r2_q[1]   <= r2_i;
    for (int k = 2; k <= PolyStages; k++) begin
      side_q[k] <= side_q[k-1];
      r2_q[k]   <= r2_q[k-1];
    end
    q1_q       <= q_i;
    qq1_q      <= qq1_d;
    ph2_q      <= ph2_d;
    pl2_q      <= pl2_d;
    r6_3_q     <= r6sum[71:24];
    hh4_q      <= hh4_d;
    hl4_q      <= hl4_d;
    ll4_q      <= ll4_d;
    r6_4_q     <= r6_3_q;
    r12_5_q    <= r12_5_d;
    r6_5_q     <= r6_4_q;
    t6_q       <= t6_d;
    g6_q       <= g6_d;
    tneg7_q    <= t6_q[63];
    tmag7_q    <= t6_q[63] ? tneg_v[62:0] : t6_q[62:0];
    gneg7_q    <= g6_q[63];
    gmag7_q    <= g6_q[63] ? gneg_v[62:0] : g6_q[62:0];
    eps4_7_q   <= {side_q[6].eps, 2'b0};
    eps48_7_q  <= eps48_7_d;
    tl8_q      <= tl8_d;
    th8_q      <= th8_d;
    gl8_q      <= gl8_d;
    gh8_q      <= gh8_d;
    tneg8_q    <= tneg7_q;
    gneg8_q    <= gneg7_q;
    emag9_q    <= emag9_d;
    hm9_q      <= hm9_d;
    tneg9_q    <= tneg8_q;
    gneg9_q    <= gneg8_q;
    esg10_q    <= esg10_d;
    fl10_q     <= fl10_d;
    fh10_q     <= fh10_d;
    gneg10_q   <= gneg9_q;
    energy11_q <= energy11_d;
    p11_q      <= p11_d;
    gneg11_q   <= gneg10_q;
  end

  assign valid_o        = v_q[PolyStages];
  assign r2_o           = r2_q[PolyStages];
  assign p_o            = p11_q;
  assign fside_o.on     = side_q[PolyStages].on;
  assign fside_o.zero   = side_q[PolyStages].zero;
  assign fside_o.gneg   = gneg11_q;
  assign fside_o.dneg   = side_q[PolyStages].dneg;
  assign fside_o.energy = energy11_q;

endmodule

`default_nettype wire

// ----- sv/ljpf_fdiv.sv -----
// ljpf_fdiv: three pipelined restoring dividers forming force magnitudes / r2
// depends on ljpf_pkg
`default_nettype none

module ljpf_fdiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [63:0]      r2_i,
  input  logic [2:0][94:0] p_i,
  input  ljpf_pkg::fside_t fside_i,
  output logic             valid_o,
  output logic [2:0][46:0] quo_o,
  output logic [2:0]       cap_o,
  output ljpf_pkg::fside_t fside_o
);
  import ljpf_pkg::*;

  logic             v_q    [0:FSteps];
  logic [2:0][63:0] rem_q  [0:FSteps];
  logic [2:0][63:0] rem_d  [1:FSteps];
  logic [2:0][46:0] bits_q [0:FSteps];
  logic [2:0][46:0] quo_q  [0:FSteps];
  logic [2:0][46:0] quo_d  [1:FSteps];
  logic [2:0]       cap_q  [0:FSteps];
  logic [63:0]      den_q  [0:FSteps];
  fside_t           fs_q   [0:FSteps];
  logic [2:0][63:0] rem0;
  logic [2:0][46:0] bits0;
  logic [2:0]       cap0;

  // start values: quotient of 2^47 or more clamps
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rem0[a]  = p_i[a][94:31];
      bits0[a] = {p_i[a][30:0], 16'b0};
      cap0[a]  = p_i[a] >= {r2_i, 31'b0};
    end
  end

  // one quotient bit per stage and axis
  always_comb begin
    for (int k = 1; k <= FSteps; k++) begin
      for (int a = 0; a < 3; a++) begin
        logic [64:0] tmp;
        logic [64:0] dif;
        logic        ge;
        tmp         = {rem_q[k-1][a], bits_q[k-1][a][46]};
        dif         = tmp - {1'b0, den_q[k-1]};
        ge          = tmp >= {1'b0, den_q[k-1]};
        rem_d[k][a] = ge ? dif[63:0] : tmp[63:0];
        quo_d[k][a] = {quo_q[k-1][a][45:0], ge};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= FSteps; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= FSteps; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= rem0;
    bits_q[0] <= bits0;
    quo_q[0]  <= '0;
    cap_q[0]  <= cap0;
    den_q[0]  <= r2_i;
    fs_q[0]   <= fside_i;
    for (int k = 1; k <= FSteps; k++) begin
      rem_q[k] <= rem_d[k];
      quo_q[k] <= quo_d[k];
      cap_q[k] <= cap_q[k-1];
      den_q[k] <= den_q[k-1];
      fs_q[k]  <= fs_q[k-1];
      for (int a = 0; a < 3; a++) begin
        bits_q[k][a] <= {bits_q[k-1][a][45:0], 1'b0};
      end
    end
  end

  assign valid_o = v_q[FSteps];
  assign quo_o   = quo_q[FSteps];
  assign cap_o   = cap_q[FSteps];
  assign fside_o = fs_q[FSteps];

endmodule

`default_nettype wire

// ----- sv/lj_pair_force.sv -----
// lj_pair_force: top level, configuration registers, unit chain and result register
// depends on ljpf_pkg, ljpf_geom, ljpf_recip, ljpf_poly, ljpf_fdiv
`default_nettype none

// Shifted Lennard-Jones pair force and energy. One request is taken per clock cycle
// (busy stays low) and its result is marked by done_o for a single cycle; results
// cannot be held off, so capture them when done_o is high. A request passes the
// distance stages, the two bit-per-stage dividers (32 stages for s2/r2 and 47 stages
// for the force quotients) with the polynomial stages between them, and the result register.
// Write configuration only while no request is in flight.
module lj_pair_force (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic [31:0]        first_x_i,
  input  logic [31:0]        first_y_i,
  input  logic [31:0]        first_z_i,
  input  logic [31:0]        second_x_i,
  input  logic [31:0]        second_y_i,
  input  logic [31:0]        second_z_i,
  input  logic [1:0]         first_species_i,
  input  logic [1:0]         second_species_i,
  output logic               done_o,
  output logic signed [47:0] force_x_o,
  output logic signed [47:0] force_y_o,
  output logic signed [47:0] force_z_o,
  output logic signed [47:0] pair_energy_o,
  output logic               zero_distance_o
);
  import ljpf_pkg::*;

  cfg_t             cfg_q;
  logic             in_valid;
  logic             g_valid, r_valid, p_valid, f_valid;
  logic [63:0]      g_r2, r_r2, p_r2;
  logic [23:0]      g_s2;
  side_t            g_side, r_side;
  logic [31:0]      r_q;
  logic [2:0][94:0] p_num;
  fside_t           p_fside, f_fside;
  logic [2:0][46:0] f_quo;
  logic [2:0]       f_cap;
  logic [2:0][47:0] force_d, force_q;
  logic [47:0]      energy_d, energy_q;
  logic             done_q, zero_q;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box         <= {BoxReset, BoxReset, BoxReset};
      cfg_q.filt_first  <= '0;
      cfg_q.filt_second <= '0;
      cfg_q.par_one     <= '0;
      cfg_q.par_two     <= '0;
      cfg_q.par_mix     <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BOX_X:       cfg_q.box[0]      <= cfg_data_i[31:0];
        REG_BOX_Y:       cfg_q.box[1]      <= cfg_data_i[31:0];
        REG_BOX_Z:       cfg_q.box[2]      <= cfg_data_i[31:0];
        REG_FILT_FIRST:  cfg_q.filt_first  <= cfg_data_i[1:0];
        REG_FILT_SECOND: cfg_q.filt_second <= cfg_data_i[1:0];
        REG_PAR_ONE:     cfg_q.par_one     <= cfg_data_i;
        REG_PAR_TWO:     cfg_q.par_two     <= cfg_data_i;
        REG_PAR_MIX:     cfg_q.par_mix     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ljpf_geom u_geom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid),
    .first_pos_i   ({first_z_i, first_y_i, first_x_i}),
    .second_pos_i  ({second_z_i, second_y_i, second_x_i}),
    .first_spec_i  (first_species_i),
    .second_spec_i (second_species_i),
    .valid_o       (g_valid),
    .r2_o          (g_r2),
    .s2_o          (g_s2),
    .side_o        (g_side)
  );

  ljpf_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_valid),
    .r2_i    (g_r2),
    .s2_i    (g_s2),
    .side_i  (g_side),
    .valid_o (r_valid),
    .q_o     (r_q),
    .r2_o    (r_r2),
    .side_o  (r_side)
  );

  ljpf_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_valid),
    .q_i     (r_q),
    .r2_i    (r_r2),
    .side_i  (r_side),
    .valid_o (p_valid),
    .r2_o    (p_r2),
    .p_o     (p_num),
    .fside_o (p_fside)
  );

  ljpf_fdiv u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .r2_i    (p_r2),
    .p_i     (p_num),
    .fside_i (p_fside),
    .valid_o (f_valid),
    .quo_o   (f_quo),
    .cap_o   (f_cap),
    .fside_o (f_fside)
  );

  // sign, filter and zero distance handling
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [47:0] mag;
      mag = {1'b0, f_quo[a]};
      if (f_fside.zero) begin
        force_d[a] = f_fside.on ? PosMax : '0;
      end else if (!f_fside.on) begin
        force_d[a] = '0;
      end else if (f_fside.gneg != f_fside.dneg[a]) begin
        force_d[a] = f_cap[a] ? NegMax : (48'b0 - mag);
      end else begin
        force_d[a] = f_cap[a] ? PosMax : mag;
      end
    end
    energy_d = f_fside.zero ? PosMax : f_fside.energy;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      done_q <= f_valid;
      zero_q <= f_valid && f_fside.zero;
    end
  end

  always_ff @(posedge clk_i) begin
    force_q  <= force_d;
    energy_q <= energy_d;
  end

  assign done_o          = done_q;
  assign zero_distance_o = zero_q;
  assign force_x_o       = force_q[0];
  assign force_y_o       = force_q[1];
  assign force_z_o       = force_q[2];
  assign pair_energy_o   = energy_q;

endmodule

`default_nettype wire

// ----- sv/ljpf_checker.sv -----
// ljpf_checker: port level checks of the pair force block, bound to the top level
// depends on ljpf_pkg and lj_pair_force
`default_nettype none

module ljpf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [47:0] force_x_o,
  input logic signed [47:0] force_y_o,
  input logic signed [47:0] force_z_o,
  input logic signed [47:0] pair_energy_o,
  input logic               zero_distance_o
);
  import ljpf_pkg::*;

  // every result belongs to a request accepted earlier, as far back as the package Latency
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without matching request");

  // zero distance flag only travels with a result
  a_zero_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_distance_o |-> done_o)
    else $error("zero distance flag outside a result");

  // zero distance saturates energy and gives equal force fields
  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_distance_o) |->
      (pair_energy_o == $signed(PosMax) && force_x_o == force_y_o && force_y_o == force_z_o))
    else $error("zero distance result not saturated");

endmodule

bind lj_pair_force ljpf_checker u_checker (.*);

`default_nettype wire
